@@ hdl/fpwc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpwc_pkg: flash page write combiner package
// Shared opcodes, default sizes and the erased byte value.
// ----------------------------------------------------------------------------
package fpwc_pkg;

  localparam int PAGE_BYTES_DEF   = 32;
  localparam int ADDRESS_BITS_DEF = 32;
  localparam int CHUNK_BYTES_DEF  = 8;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NONE    = 2'd3
  } fpwc_op_t;

endpackage

@@ hdl/fpwc_in_if.sv @@
// ----------------------------------------------------------------------------
// fpwc_in_if: request channel of the page write combiner
// Valid/ready channel carrying one write, flush or discard request.
// ----------------------------------------------------------------------------
interface fpwc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] start_address;
  logic [3:0]  byte_count;
  logic [63:0] chunk_bytes;

  modport source (output valid, opcode, start_address, byte_count, chunk_bytes,
                  input ready);
  modport sink   (input valid, opcode, start_address, byte_count, chunk_bytes,
                  output ready);
endinterface

@@ hdl/fpwc_out_if.sv @@
// ----------------------------------------------------------------------------
// fpwc_out_if: page word channel of the page write combiner
// Valid/ready channel carrying one 64-bit word of a flushed page.
// ----------------------------------------------------------------------------
interface fpwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_address;
  logic [1:0]  word_index;
  logic [63:0] word_data;
  logic        last_word;

  modport source (output valid, page_address, word_index, word_data, last_word,
                  input ready);
  modport sink   (input valid, page_address, word_index, word_data, last_word,
                  output ready);
endinterface

@@ hdl/fpwc_ram.sv @@
// ----------------------------------------------------------------------------
// fpwc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/flash_page_write_combiner.sv @@
// ----------------------------------------------------------------------------
// flash_page_write_combiner: gathers write chunks into one flash page buffer
//
// in_req carries requests: write chunk, flush page or discard buffer. A chunk
// byte whose page differs from the buffered page first flushes the buffered
// page, then opens a new page; a later page change in the same request drops
// the buffer unflushed. out_res carries the flushed page as 64-bit
// little-endian words, erased bytes as 0xFF, last word marked.
// A write request stores its bytes, one byte per cycle, through the page
// RAM write port, unless a page change stops it for a flush. A flush reads
// the page RAM byte by byte (read, then capture), packs eight bytes into
// each word and holds it on out_res until taken. in_req.ready is high
// only while the sequencer is idle; one request is handled at a time.
//
// Reset (rst_n low, synchronous) empties the buffer and idles the sequencer;
// the page RAM is not cleared, the written mask guards every read.
// When the receiver stalls, the current word holds on out_res and the
// sequencer waits.
// ----------------------------------------------------------------------------
module flash_page_write_combiner
  import fpwc_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  fpwc_in_if.sink  in_req,
  fpwc_out_if.source out_res
);

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int BASE_W = ADDRESS_BITS - OFF_W;
  localparam int CNT_W  = $clog2(CHUNK_BYTES + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WRITE  = 5'b00010,
    S_FL_RD  = 5'b00100,
    S_FL_CAP = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [63:0]             data_r, data_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic                    flushed_r, flushed_nxt;
  logic                    resume_wr_r, resume_wr_nxt;
  logic [PAGE_BYTES-1:0]   mask_r, mask_nxt;
  logic [BASE_W-1:0]       base_r, base_nxt;
  logic                    open_r, open_nxt;
  logic [OFF_W-1:0]        off_r, off_nxt;
  logic [63:0]             word_r, word_nxt;

  logic [BASE_W-1:0] cur_page;
  logic [OFF_W-1:0]  cur_off;
  logic              need_new;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        cap_byte;
  logic              last_w;
  logic              in_acc;

  assign cur_page = addr_r[ADDRESS_BITS-1:OFF_W];
  assign cur_off  = addr_r[OFF_W-1:0];
  assign need_new = !open_r || (cur_page != base_r);
  assign cap_byte = mask_r[off_r] ? ram_rdata : ERASED_BYTE;
  assign last_w   = (off_r == OFF_W'(PAGE_BYTES - 1));
  assign in_acc   = in_req.valid && in_req.ready;

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_res.valid        = (state_r == S_EMIT);
  assign out_res.page_address = 32'({base_r, {OFF_W{1'b0}}});
  assign out_res.word_index   = 2'(off_r >> 3);
  assign out_res.word_data    = word_r;
  assign out_res.last_word    = last_w;

  fpwc_ram #(
    .WIDTH (8),
    .DEPTH (PAGE_BYTES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_off),
    .wdata (data_r[7:0]),
    .raddr (off_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    rem_nxt       = rem_r;
    flushed_nxt   = flushed_r;
    resume_wr_nxt = resume_wr_r;
    mask_nxt      = mask_r;
    base_nxt      = base_r;
    open_nxt      = open_r;
    off_nxt       = off_r;
    word_nxt      = word_r;
    ram_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (fpwc_op_t'(in_req.opcode))
            OP_WRITE: begin
              addr_nxt    = in_req.start_address[ADDRESS_BITS-1:0];
              data_nxt    = in_req.chunk_bytes;
              rem_nxt     = (in_req.byte_count > 4'(CHUNK_BYTES)) ?
                            CNT_W'(CHUNK_BYTES) : CNT_W'(in_req.byte_count);
              flushed_nxt = 1'b0;
              state_nxt   = S_WRITE;
            end
            OP_FLUSH: begin
              if (open_r) begin
                resume_wr_nxt = 1'b0;
                off_nxt       = '0;
                state_nxt     = S_FL_RD;
              end
            end
            OP_DISCARD: begin
              mask_nxt = '0;
              open_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end else if (need_new && open_r && !flushed_r) begin
          // flush the old page, then revisit this byte
          flushed_nxt   = 1'b1;
          resume_wr_nxt = 1'b1;
          off_nxt       = '0;
          state_nxt     = S_FL_RD;
        end else begin
          ram_we = 1'b1;
          if (need_new) begin
            // a page change after this request already flushed drops the buffer unwritten
            mask_nxt = '0;
            base_nxt = cur_page;
            open_nxt = 1'b1;
          end
          mask_nxt[cur_off] = 1'b1;
          addr_nxt = addr_r + ADDRESS_BITS'(1);
          data_nxt = {8'h00, data_r[63:8]};
          rem_nxt  = rem_r - CNT_W'(1);
        end
      end
      S_FL_RD: begin
        state_nxt = S_FL_CAP;
      end
      S_FL_CAP: begin
        word_nxt = {cap_byte, word_r[63:8]};
        if (off_r[2:0] == 3'd7) begin
          state_nxt = S_EMIT;
        end else begin
          off_nxt   = off_r + OFF_W'(1);
          state_nxt = S_FL_RD;
        end
      end
      S_EMIT: begin
        if (out_res.ready) begin
          if (last_w) begin
            mask_nxt  = '0;
            open_nxt  = 1'b0;
            state_nxt = resume_wr_r ? S_WRITE : S_IDLE;
          end else begin
            off_nxt   = off_r + OFF_W'(1);
            state_nxt = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      base_r      <= '0;
      open_r      <= 1'b0;
      flushed_r   <= 1'b0;
      resume_wr_r <= 1'b0;
      rem_r       <= '0;
      off_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      base_r      <= base_nxt;
      open_r      <= open_nxt;
      flushed_r   <= flushed_nxt;
      resume_wr_r <= resume_wr_nxt;
      rem_r       <= rem_nxt;
      off_r       <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    word_r <= word_nxt;
  end

endmodule

@@ dv/tb_flash_page_write_combiner.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flash_page_write_combiner: self-checking bench for the page combiner
// Drives write, flush and discard requests, predicts every flushed page word
// from a behavioural copy of the page buffer and checks out_res in order,
// under four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_flash_page_write_combiner;
  import fpwc_pkg::*;

  localparam int PAGE_SIZE   = PAGE_BYTES_DEF;
  localparam int CHUNK_MAX   = CHUNK_BYTES_DEF;
  localparam int PAGE_WORDS  = PAGE_SIZE / 8;
  localparam int OFF_BITS    = $clog2(PAGE_SIZE);
  localparam int RANDOM_REQS = 300;
  localparam int DRAIN_WAIT  = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    fpwc_op_t    opcode;
    logic [31:0] start_address;
    logic [3:0]  byte_count;
    logic [63:0] chunk_bytes;
  } request_t;

  typedef struct {
    logic [31:0] page_address;
    logic [1:0]  word_index;
    logic [63:0] word_data;
    logic        last_word;
  } page_word_t;

  logic clk;
  logic rst_n;

  fpwc_in_if  in_req ();
  fpwc_out_if out_res ();

  flash_page_write_combiner i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  request_t   request_q[$];
  page_word_t pending_words[$];
  request_t   cur_req;

  // behavioural copy of the page buffer
  logic [7:0]              buf_bytes [PAGE_SIZE];
  logic [PAGE_SIZE-1:0]    buf_mask;
  logic [31-OFF_BITS:0]    buf_page;
  bit                      buf_open;

  int total_requests;
  int accepted;
  int words_checked;
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Emit the open page as words; return how many were queued.
  function automatic int flush_buffered_page();
    page_word_t pw;
    logic [7:0] b;
    int         off;
    if (!buf_open) return 0;
    for (int w = 0; w < PAGE_WORDS; w++) begin
      pw.page_address = {buf_page, {OFF_BITS{1'b0}}};
      pw.word_index   = 2'(w);
      pw.word_data    = '0;
      for (int k = 0; k < 8; k++) begin
        off = w * 8 + k;
        b   = buf_mask[off] ? buf_bytes[off] : ERASED_BYTE;
        pw.word_data[8*k +: 8] = b;
      end
      pw.last_word = (w == PAGE_WORDS - 1);
      pending_words.push_back(pw);
    end
    buf_mask = '0;
    buf_open = 1'b0;
    return PAGE_WORDS;
  endfunction

  task automatic combine_request(input request_t r);
    int                   n;
    int                   made;
    logic [31:0]          a;
    logic [31-OFF_BITS:0] pg;
    logic [OFF_BITS-1:0]  off;
    made = 0;
    case (r.opcode)
      OP_FLUSH: made = flush_buffered_page();
      OP_DISCARD: begin
        buf_mask = '0;
        buf_open = 1'b0;
      end
      OP_WRITE: begin
        n = (r.byte_count > CHUNK_MAX) ? CHUNK_MAX : int'(r.byte_count);
        for (int i = 0; i < n; i++) begin
          a   = r.start_address + 32'(i);
          pg  = a[31:OFF_BITS];
          off = a[OFF_BITS-1:0];
          if (!buf_open || pg != buf_page) begin
            // a request writes out at most one page, at its first crossing from an open page
            if (made == 0) made += flush_buffered_page();
            buf_mask = '0;
            buf_page = pg;
            buf_open = 1'b1;
          end
          buf_bytes[off] = r.chunk_bytes[8*i +: 8];
          buf_mask[off]  = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int idle_phase();
    int p;
    p = (total_requests > 0) ? (accepted * 4) / total_requests : 0;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic request_t make_request(input fpwc_op_t op, input logic [31:0] addr,
                                            input logic [3:0] cnt, input logic [63:0] data);
    request_t r;
    r.opcode        = op;
    r.start_address = addr;
    r.byte_count    = cnt;
    r.chunk_bytes   = data;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic build_stimulus();
    int          counted;
    int          chunks;
    int          pick;
    logic [31:0] base;
    request_t    r;

    // directed: empty flush, discard, unknown op, zero count, wrap, oversized counts
    request_q.push_back(make_request(OP_FLUSH, 32'h0, 4'd0, 64'h0));
    request_q.push_back(make_request(OP_DISCARD, 32'hFFFF_FFFF, 4'hF, '1));
    request_q.push_back(make_request(OP_NONE, 32'hFFFF_FFFF, 4'hF, '1));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_0100, 4'd0, '1));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_0000, 4'd8, 64'h0123_4567_89AB_CDEF));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_0018, 4'd8, 64'h0));
    request_q.push_back(make_request(OP_FLUSH, 32'h0, 4'd0, 64'h0));
    request_q.push_back(make_request(OP_WRITE, 32'hFFFF_FFFC, 4'd8, rand64()));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_0005, 4'hF, '1));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_001E, 4'd9, rand64()));
    request_q.push_back(make_request(OP_DISCARD, 32'h0, 4'd0, 64'h0));
    request_q.push_back(make_request(OP_FLUSH, 32'h0, 4'd0, 64'h0));
    request_q.push_back(make_request(OP_WRITE, 32'hFFFF_FFE0, 4'd1, 64'hAA));
    request_q.push_back(make_request(OP_WRITE, 32'h1234_5678, 4'd3, rand64()));
    request_q.push_back(make_request(OP_NONE, 32'(rand64()), 4'd8, rand64()));
    request_q.push_back(make_request(OP_WRITE, 32'h1234_5670, 4'd0, rand64()));
    request_q.push_back(make_request(OP_WRITE, 32'h1234_5660, 4'd8, rand64()));
    request_q.push_back(make_request(OP_FLUSH, 32'h0, 4'd0, 64'h0));
    request_q.push_back(make_request(OP_WRITE, 32'hFFFF_FFFF, 4'd8, 64'h0));
    request_q.push_back(make_request(OP_FLUSH, 32'hFFFF_FFFF, 4'hF, '1));
    request_q.push_back(make_request(OP_WRITE, 32'h0000_0000, 4'hF, '1));
    request_q.push_back(make_request(OP_FLUSH, 32'h0, 4'd0, 64'h0));

    counted = 0;
    while (counted < RANDOM_REQS) begin
      if (roll(75)) begin
        // a burst of chunks around one page, then often close it with a flush or discard
        pick = $urandom_range(0, 7);
        if (pick == 0) base = {27'h7FF_FFFF, 5'd0};
        else if (pick == 1) base = 32'h0;
        else base = {27'($urandom), 5'd0};
        chunks = $urandom_range(1, 6);
        for (int c = 0; c < chunks; c++) begin
          r = make_request(OP_WRITE, base + 32'($urandom_range(0, PAGE_SIZE - 1)),
                           4'($urandom_range(1, CHUNK_MAX)), rand64());
          if (roll(5)) r.byte_count = 4'($urandom_range(CHUNK_MAX + 1, 15));
          request_q.push_back(r);
          counted++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          request_q.push_back(make_request(OP_FLUSH, $urandom, 4'($urandom), rand64()));
          counted++;
        end else if (pick < 75) begin
          request_q.push_back(make_request(OP_DISCARD, $urandom, 4'($urandom), rand64()));
          counted++;
        end
      end else begin
        r = make_request(fpwc_op_t'($urandom_range(0, 3)), $urandom,
                         4'($urandom_range(0, 15)), rand64());
        request_q.push_back(r);
        if (r.opcode != OP_NONE && !(r.opcode == OP_WRITE && r.byte_count == 0))
          counted++;
      end
    end
    total_requests = request_q.size();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        combine_request(cur_req);
        accepted++;
      end
      if (!in_req.valid || in_req.ready) begin
        if (request_q.size() > 0 &&
            !((idle_phase() == 1 && roll(67)) || (idle_phase() == 3 && roll(27)))) begin
          cur_req = request_q.pop_front();
          in_req.valid         <= 1'b1;
          in_req.opcode        <= cur_req.opcode;
          in_req.start_address <= cur_req.start_address;
          in_req.byte_count    <= cur_req.byte_count;
          in_req.chunk_bytes   <= cur_req.chunk_bytes;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // page word monitor
  always @(posedge clk) begin
    page_word_t exp_w;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("page word %h/%0d with none pending",
                                    out_res.page_address, out_res.word_index));
        end else begin
          exp_w = pending_words.pop_front();
          words_checked++;
          if (out_res.page_address !== exp_w.page_address)
            report_mismatch($sformatf("page_address %h, want %h",
                                      out_res.page_address, exp_w.page_address));
          if (out_res.word_index !== exp_w.word_index)
            report_mismatch($sformatf("word_index %0d, want %0d",
                                      out_res.word_index, exp_w.word_index));
          if (out_res.word_data !== exp_w.word_data)
            report_mismatch($sformatf("word_data %h, want %h",
                                      out_res.word_data, exp_w.word_data));
          if (out_res.last_word !== exp_w.last_word)
            report_mismatch($sformatf("last_word %b, want %b",
                                      out_res.last_word, exp_w.last_word));
        end
      end
      out_res.ready <= !((idle_phase() == 2 && roll(67)) || (idle_phase() == 3 && roll(27)));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests accepted",
               cycles, accepted, total_requests);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_req.valid         = 1'b0;
    in_req.opcode        = OP_NONE;
    in_req.start_address = '0;
    in_req.byte_count    = '0;
    in_req.chunk_bytes   = '0;
    out_res.ready        = 1'b0;
    buf_mask             = '0;
    buf_page             = '0;
    buf_open             = 1'b0;
    accepted             = 0;
    words_checked        = 0;
    errors               = 0;
    cycles               = 0;
    total_requests       = 0;
    build_stimulus();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_requests) @(negedge clk);
    while (pending_words.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("%0d requests driven, %0d page words checked across four idle/stall phases",
             total_requests, words_checked);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d page words outstanding", errors, pending_words.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
